@@ rtl/asba_pkg.sv @@
// Shared constants, types and elaboration-time tables of the spectrum band analyzer.
`timescale 1ns / 1ps

package asba_pkg;

  localparam int unsigned FRAME_SIZE    = 1024;
  localparam int unsigned SPECTRUM_BINS = 64;
  localparam int unsigned BAND_COUNT    = 8;

  localparam int unsigned LOG_N      = $clog2(FRAME_SIZE);
  localparam int unsigned HALF_SIZE  = FRAME_SIZE / 2;
  localparam int unsigned BIN_W      = $clog2(SPECTRUM_BINS);
  localparam int unsigned BAND_W     = $clog2(BAND_COUNT);
  localparam int unsigned STG_W      = $clog2(LOG_N);
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned MAG_W      = 17;
  localparam int unsigned WIN_W      = 16;
  localparam int unsigned TW_W       = 32;
  localparam int unsigned WORK_W     = LOG_N + 18;
  localparam int unsigned PROD_W     = WORK_W + TW_W;
  localparam int unsigned SQ_W       = 2 * WORK_W + 4;
  localparam int unsigned ROOT_W     = SQ_W / 2;
  localparam int unsigned ROOT_STEPS = SQ_W / 2;
  localparam int unsigned RS_W       = $clog2(ROOT_STEPS);
  localparam int unsigned LEVEL_W    = LOG_N + 16;
  localparam int unsigned BAND_BINS  = HALF_SIZE / BAND_COUNT;
  localparam int unsigned BAND_SHIFT = $clog2(BAND_BINS);
  localparam int unsigned SUM_W      = MAG_W + BAND_SHIFT + 2;

  localparam logic [MAG_W-1:0] MAG_MAX       = 17'h1FFFF;
  localparam logic [MAG_W-1:0] THRESHOLD_RST = 17'd32768;

  localparam longint          Q30_ONE    = 64'sd1073741824;
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
  localparam longint unsigned WIN_DEN    = FRAME_SIZE - 1;

  // Horner divisors of the cosine and sine series, innermost term first.
  localparam longint COS_DIV [7] = '{182, 132, 90, 56, 30, 12, 2};
  localparam longint SIN_DIV [7] = '{210, 156, 110, 72, 42, 20, 6};

  typedef struct packed {
    logic signed [63:0] c;
    logic signed [63:0] s;
  } trig_t;

  typedef logic [WIN_W-1:0]       win_rom_t [FRAME_SIZE];
  typedef logic signed [TW_W-1:0] tw_rom_t  [HALF_SIZE];

  // Cosine and sine in Q2.30 of a phase given as a 32-bit fraction of a turn.
  function automatic trig_t turn_cos_sin(input logic [31:0] phase);
    longint unsigned frac;
    longint x;
    longint x2;
    longint cv;
    longint sv;
    trig_t  res;
    frac = {34'd0, phase[29:0]};
    x    = longint'((frac * TWO_PI_Q30) >> 32);
    x2   = (x * x) / Q30_ONE;
    cv   = Q30_ONE;
    sv   = Q30_ONE;
    for (int i = 0; i < 7; i++) begin
      cv = Q30_ONE - ((x2 * cv) / Q30_ONE) / COS_DIV[i];
      sv = Q30_ONE - ((x2 * sv) / Q30_ONE) / SIN_DIV[i];
    end
    if (cv > Q30_ONE) cv = Q30_ONE;
    if (cv < -Q30_ONE) cv = -Q30_ONE;
    sv = (x * sv) / Q30_ONE;
    if (sv > Q30_ONE) sv = Q30_ONE;
    if (sv < -Q30_ONE) sv = -Q30_ONE;
    case (phase[31:30])
      2'd0:    begin res.c = cv;  res.s = sv;  end
      2'd1:    begin res.c = -sv; res.s = cv;  end
      2'd2:    begin res.c = -cv; res.s = -sv; end
      default: begin res.c = sv;  res.s = -cv; end
    endcase
    return res;
  endfunction

  function automatic win_rom_t gen_window();
    win_rom_t        rom;
    trig_t           t;
    longint unsigned ph;
    longint          wv;
    for (int i = 0; i < FRAME_SIZE; i++) begin
      ph     = ((longint'(i) << 32) + WIN_DEN / 2) / WIN_DEN;
      t      = turn_cos_sin(ph[31:0]);
      wv     = (Q30_ONE - t.c + 64'sd32768) >>> 16;
      rom[i] = wv[WIN_W-1:0];
    end
    return rom;
  endfunction

  function automatic tw_rom_t gen_tw_re();
    tw_rom_t         rom;
    trig_t           t;
    longint unsigned ph;
    for (int i = 0; i < HALF_SIZE; i++) begin
      ph     = longint'(i) << (32 - LOG_N);
      t      = turn_cos_sin(ph[31:0]);
      rom[i] = t.c[TW_W-1:0];
    end
    return rom;
  endfunction

  function automatic tw_rom_t gen_tw_im();
    tw_rom_t         rom;
    trig_t           t;
    longint unsigned ph;
    longint          ns;
    for (int i = 0; i < HALF_SIZE; i++) begin
      ph     = longint'(i) << (32 - LOG_N);
      t      = turn_cos_sin(ph[31:0]);
      ns     = -t.s;
      rom[i] = ns[TW_W-1:0];
    end
    return rom;
  endfunction

  localparam win_rom_t WIN_ROM = gen_window();
  localparam tw_rom_t  TW_RE   = gen_tw_re();
  localparam tw_rom_t  TW_IM   = gen_tw_im();

endpackage

@@ rtl/asba_if.sv @@
// Handshake channel interfaces of the spectrum band analyzer.
`timescale 1ns / 1ps

interface asba_sample_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [asba_pkg::SAMPLE_W-1:0]    sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface asba_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [asba_pkg::MAG_W-1:0]   beat_threshold;
  modport source (output valid, output beat_threshold, input ready);
  modport sink   (input valid, input beat_threshold, output ready);
endinterface

interface asba_result_if;
  logic                         valid;
  logic                         ready;
  logic [asba_pkg::IDX_W-1:0]   bin_index;
  logic [asba_pkg::MAG_W-1:0]   bin_magnitude;
  logic [asba_pkg::MAG_W-1:0]   band_average;
  logic [asba_pkg::MAG_W-1:0]   level;
  logic [asba_pkg::MAG_W-1:0]   bass_average;
  logic [asba_pkg::MAG_W-1:0]   mid_average;
  logic [asba_pkg::MAG_W-1:0]   treble_average;
  logic                         beat;
  logic                         last;
  modport source (output valid, output bin_index, output bin_magnitude, output band_average,
                  output level, output bass_average, output mid_average,
                  output treble_average, output beat, output last, input ready);
  modport sink   (input valid, input bin_index, input bin_magnitude, input band_average,
                  input level, input bass_average, input mid_average,
                  input treble_average, input beat, input last, output ready);
endinterface

@@ rtl/asba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module asba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/audio_spectrum_band_analyzer.sv @@
// Top level of the spectrum band analyzer: capture, windowing, FFT, magnitudes and output.
// Each sample word is captured, windowed and then stored; the frame's last one starts the FFT.
// FFT: (N/2)*log2(N) butterflies, each read, multiplied and written back on one shared multiplier.
// Magnitudes: 2 squares and a 30-step root per bin, 512 bins.
// Then 64 result words, each read, loaded and offered; the next is read once the one before is taken.
// Reset is asynchronous and clears control state only; no memory needs a clearing pass.
`timescale 1ns / 1ps

module audio_spectrum_band_analyzer (
  input  logic          clk_i,
  input  logic          rst_ni,
  asba_sample_if.sink   sample_i,
  asba_cfg_if.sink      cfg_i,
  asba_result_if.source result_o
);

  localparam int unsigned N     = asba_pkg::FRAME_SIZE;
  localparam int unsigned LOGN  = asba_pkg::LOG_N;
  localparam int unsigned WW    = asba_pkg::WORK_W;
  localparam int unsigned PW    = asba_pkg::PROD_W;
  localparam int unsigned SQW   = asba_pkg::SQ_W;
  localparam int unsigned RTW   = asba_pkg::ROOT_W;
  localparam int unsigned SUMW  = asba_pkg::SUM_W;
  localparam int unsigned MW    = asba_pkg::MAG_W;
  localparam int unsigned BINW  = asba_pkg::BIN_W;
  localparam int unsigned STGW  = asba_pkg::STG_W;
  localparam int unsigned LVW   = asba_pkg::LEVEL_W;
  localparam int unsigned BANDW = asba_pkg::BAND_W;

  // Sequencer codes.
  localparam logic [4:0] S_COLLECT = 5'd0;
  localparam logic [4:0] S_WMUL    = 5'd1;
  localparam logic [4:0] S_WWR     = 5'd2;
  localparam logic [4:0] S_RDA     = 5'd3;
  localparam logic [4:0] S_RDB     = 5'd4;
  localparam logic [4:0] S_LB      = 5'd5;
  localparam logic [4:0] S_M0      = 5'd6;
  localparam logic [4:0] S_M1      = 5'd7;
  localparam logic [4:0] S_M2      = 5'd8;
  localparam logic [4:0] S_M3      = 5'd9;
  localparam logic [4:0] S_M4      = 5'd10;
  localparam logic [4:0] S_WRB     = 5'd11;
  localparam logic [4:0] S_WRA     = 5'd12;
  localparam logic [4:0] S_MRD     = 5'd13;
  localparam logic [4:0] S_SQ0     = 5'd14;
  localparam logic [4:0] S_SQ1     = 5'd15;
  localparam logic [4:0] S_SQ2     = 5'd16;
  localparam logic [4:0] S_ROOT    = 5'd17;
  localparam logic [4:0] S_MACC    = 5'd18;
  localparam logic [4:0] S_FIN     = 5'd19;
  localparam logic [4:0] S_ORD     = 5'd20;
  localparam logic [4:0] S_OLD     = 5'd21;
  localparam logic [4:0] S_OSEND   = 5'd22;

  localparam logic signed [PW:0] RND_Q30 = (PW+1)'(64'd1 << 29);
  localparam logic signed [PW-1:0] RND_Q15 = PW'(64'd1 << 14);

  function automatic logic [LOGN-1:0] bit_rev(input logic [LOGN-1:0] v);
    logic [LOGN-1:0] r;
    for (int b = 0; b < LOGN; b++) begin
      r[LOGN-1-b] = v[b];
    end
    return r;
  endfunction

  // Control state.
  logic [4:0]            state_q, state_d;
  logic [LOGN-1:0]       cnt_q;
  logic [LVW-1:0]        level_sum_q;
  logic [STGW-1:0]       stage_q;
  logic [LOGN-2:0]       bf_q;
  logic [LOGN-2:0]       k_q;
  logic [asba_pkg::RS_W-1:0] step_q;
  logic [BINW-1:0]       oidx_q;
  logic                  out_valid_q;
  logic [MW-1:0]         thr_q;

  // Datapath registers.
  logic signed [asba_pkg::SAMPLE_W-1:0] smp_q;
  logic [asba_pkg::WIN_W-1:0]           win_q;
  logic signed [PW-1:0]                 p_q;
  logic signed [PW-1:0]                 acc_q;
  logic [2*WW-1:0]                      a_q, b_q;
  logic signed [asba_pkg::TW_W-1:0]     twr_q, twi_q;
  logic signed [WW-1:0]                 tr_q, ti_q;
  logic [SQW-1:0]                       v_q, r_q, bit_q;
  logic [SUMW-1:0]                      band_acc_q;
  logic [SUMW-1:0]                      band_sum_q [asba_pkg::BAND_COUNT];
  logic [MW-1:0]                        level_q, bass_q, mid_q, treble_q;
  logic                                 beat_q;
  logic [asba_pkg::IDX_W-1:0]           o_idx_q;
  logic [MW-1:0]                        o_mag_q, o_band_q;
  logic                                 o_last_q;

  // Shared multiplier.
  logic signed [WW-1:0]              mul_a;
  logic signed [asba_pkg::TW_W-1:0]  mul_b;
  logic signed [PW-1:0]              mul_p;

  // Butterfly addressing.
  logic [LOGN-2:0] bf_mask, bf_j;
  logic [LOGN-1:0] addr_a, addr_b;
  logic [LOGN-2:0] tw_idx;
  logic [STGW:0]   tw_shift;

  // Work memory ports.
  logic              work_we;
  logic [LOGN-1:0]   work_waddr, work_raddr;
  logic [2*WW-1:0]   work_wdata, work_rdata;
  logic              low_we;
  logic [MW-1:0]     low_rdata;

  logic signed [WW-1:0] a_re, a_im, b_re, b_im, rd_re, rd_im;
  logic signed [PW:0]   bf_sum;
  logic signed [PW:0]   bf_rnd;
  logic signed [PW-1:0] win_rnd;
  logic [PW:0]          sq_sum;
  logic [SQW:0]         trial;
  logic                 take;
  logic [RTW:0]         mag_full;
  logic [MW-1:0]        mag;
  logic [SUMW-1:0]      band_next;
  logic [SUMW-1:0]      band_sel, band_avg;
  logic [SUMW-1:0]      bass_sum, mid_sum, treble_sum;
  logic [SUMW-1:0]      bass_avg, mid_avg, treble_avg;
  logic [LVW-1:0]       level_avg;
  logic [asba_pkg::SAMPLE_W-1:0] smp_abs;

  logic in_fire, out_fire;

  assign in_fire  = sample_i.valid && sample_i.ready;
  assign out_fire = out_valid_q && result_o.ready;

  assign sample_i.ready = (state_q == S_COLLECT);
  assign cfg_i.ready    = 1'b1;

  assign a_re  = a_q[2*WW-1:WW];
  assign a_im  = a_q[WW-1:0];
  assign b_re  = b_q[2*WW-1:WW];
  assign b_im  = b_q[WW-1:0];
  assign rd_re = work_rdata[2*WW-1:WW];
  assign rd_im = work_rdata[WW-1:0];

  // A butterfly pairs a and a + half, where half = 2^stage; the group index is the
  // counter with a zero bit inserted at the stage position.
  assign bf_mask  = ((LOGN-1)'(1) << stage_q) - (LOGN-1)'(1);
  assign bf_j     = bf_q & bf_mask;
  assign addr_a   = {bf_q & ~bf_mask, 1'b0} | {1'b0, bf_j};
  assign addr_b   = addr_a | (LOGN'(1) << stage_q);
  assign tw_shift = (STGW+1)'(LOGN - 1) - (STGW+1)'(stage_q);
  assign tw_idx   = bf_j << tw_shift;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_WMUL: begin
        mul_a = WW'(smp_q);
        mul_b = asba_pkg::TW_W'({1'b0, win_q});
      end
      S_M0: begin mul_a = b_re; mul_b = twr_q; end
      S_M1: begin mul_a = b_im; mul_b = twi_q; end
      S_M2: begin mul_a = b_re; mul_b = twi_q; end
      S_M3: begin mul_a = b_im; mul_b = twr_q; end
      S_SQ0: begin mul_a = rd_re; mul_b = asba_pkg::TW_W'(rd_re); end
      S_SQ1: begin mul_a = rd_im; mul_b = asba_pkg::TW_W'(rd_im); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Round half up by 2^30 of the two-product sum; the M2 arm subtracts, M4 adds.
  assign bf_sum  = (state_q == S_M2) ? ((PW+1)'(acc_q) - (PW+1)'(p_q))
                                     : ((PW+1)'(acc_q) + (PW+1)'(p_q));
  assign bf_rnd  = (bf_sum + RND_Q30) >>> 30;
  assign win_rnd = (p_q + RND_Q15) >>> 15;

  assign sq_sum = (PW+1)'(unsigned'(acc_q)) + (PW+1)'(unsigned'(p_q));
  assign trial  = {1'b0, r_q} + {1'b0, bit_q};
  assign take   = ({1'b0, v_q} >= trial);

  assign mag_full  = (RTW+1)'(r_q[RTW-1:0]) + (RTW+1)'(N / 2);
  assign mag       = ((mag_full >> LOGN) > (RTW+1)'(asba_pkg::MAG_MAX)) ? asba_pkg::MAG_MAX
                                                                       : MW'(mag_full >> LOGN);
  assign band_next = band_acc_q + SUMW'(mag);

  assign smp_abs = smp_q[asba_pkg::SAMPLE_W-1] ? asba_pkg::SAMPLE_W'(-smp_q)
                                              : asba_pkg::SAMPLE_W'(smp_q);

  // Region averages come from whole bands: bass is the first quarter of the bins,
  // mid the second quarter and treble the upper half.
  assign bass_sum   = band_sum_q[0] + band_sum_q[1];
  assign mid_sum    = band_sum_q[2] + band_sum_q[3];
  assign treble_sum = band_sum_q[4] + band_sum_q[5] + band_sum_q[6] + band_sum_q[7];
  assign bass_avg   = (bass_sum + SUMW'(N / 16)) >> (LOGN - 3);
  assign mid_avg    = (mid_sum + SUMW'(N / 16)) >> (LOGN - 3);
  assign treble_avg = (treble_sum + SUMW'(N / 8)) >> (LOGN - 2);
  assign level_avg  = (level_sum_q + LVW'(N / 4)) >> (LOGN - 1);

  assign band_sel = band_sum_q[oidx_q[BANDW-1:0]];
  assign band_avg = (band_sel + SUMW'(asba_pkg::BAND_BINS / 2)) >> asba_pkg::BAND_SHIFT;

  // Work memory port selection.
  always_comb begin
    work_we    = 1'b0;
    work_waddr = addr_a;
    work_wdata = {a_re + tr_q, a_im + ti_q};
    work_raddr = addr_a;
    unique case (state_q)
      S_WWR: begin
        work_we    = 1'b1;
        work_waddr = bit_rev(cnt_q);
        work_wdata = {win_rnd[WW-1:0], {WW{1'b0}}};
      end
      S_WRB: begin
        work_we    = 1'b1;
        work_waddr = addr_b;
        work_wdata = {a_re - tr_q, a_im - ti_q};
      end
      S_WRA: begin
        work_we = 1'b1;
      end
      S_RDB, S_LB: begin
        work_raddr = addr_b;
      end
      S_MRD, S_SQ0, S_SQ1: begin
        work_raddr = {1'b0, k_q};
      end
      default: begin
        work_we = 1'b0;
      end
    endcase
  end

  assign low_we = (state_q == S_MACC) && ((LOGN-1)'(k_q) < (LOGN-1)'(asba_pkg::SPECTRUM_BINS));

  asba_ram #(
    .WIDTH (2 * WW),
    .DEPTH (N)
  ) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (work_we),
    .waddr_i (work_waddr),
    .wdata_i (work_wdata),
    .raddr_i (work_raddr),
    .rdata_o (work_rdata)
  );

  asba_ram #(
    .WIDTH (MW),
    .DEPTH (asba_pkg::SPECTRUM_BINS)
  ) u_low_ram (
    .clk_i   (clk_i),
    .we_i    (low_we),
    .waddr_i (k_q[BINW-1:0]),
    .wdata_i (mag),
    .raddr_i (oidx_q),
    .rdata_o (low_rdata)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_COLLECT: if (in_fire) state_d = S_WMUL;
      S_WMUL:    state_d = S_WWR;
      S_WWR:     state_d = (cnt_q == LOGN'(N - 1)) ? S_RDA : S_COLLECT;
      S_RDA:     state_d = S_RDB;
      S_RDB:     state_d = S_LB;
      S_LB:      state_d = S_M0;
      S_M0:      state_d = S_M1;
      S_M1:      state_d = S_M2;
      S_M2:      state_d = S_M3;
      S_M3:      state_d = S_M4;
      S_M4:      state_d = S_WRB;
      S_WRB:     state_d = S_WRA;
      S_WRA: begin
        if ((&bf_q) && (stage_q == STGW'(LOGN - 1))) state_d = S_MRD;
        else state_d = S_RDA;
      end
      S_MRD:     state_d = S_SQ0;
      S_SQ0:     state_d = S_SQ1;
      S_SQ1:     state_d = S_SQ2;
      S_SQ2:     state_d = S_ROOT;
      S_ROOT:    if (step_q == asba_pkg::RS_W'(asba_pkg::ROOT_STEPS - 1)) state_d = S_MACC;
      S_MACC:    state_d = (&k_q) ? S_FIN : S_MRD;
      S_FIN:     state_d = S_ORD;
      S_ORD:     state_d = S_OLD;
      S_OLD:     state_d = S_OSEND;
      S_OSEND: begin
        if (out_fire) state_d = o_last_q ? S_COLLECT : S_ORD;
      end
      default:   state_d = S_COLLECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_COLLECT;
      cnt_q       <= '0;
      level_sum_q <= '0;
      stage_q     <= '0;
      bf_q        <= '0;
      k_q         <= '0;
      step_q      <= '0;
      oidx_q      <= '0;
      out_valid_q <= 1'b0;
      thr_q       <= asba_pkg::THRESHOLD_RST;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        thr_q <= cfg_i.beat_threshold;
      end
      case (state_q)
        S_WWR: begin
          cnt_q       <= cnt_q + LOGN'(1);
          level_sum_q <= level_sum_q + LVW'(smp_abs);
          stage_q     <= '0;
          bf_q        <= '0;
        end
        S_WRA: begin
          bf_q <= bf_q + (LOGN-1)'(1);
          if (&bf_q) begin
            stage_q <= stage_q + STGW'(1);
          end
          k_q <= '0;
        end
        S_SQ2: step_q <= '0;
        S_ROOT: step_q <= step_q + asba_pkg::RS_W'(1);
        S_MACC: k_q <= k_q + (LOGN-1)'(1);
        S_FIN: oidx_q <= '0;
        S_OLD: out_valid_q <= 1'b1;
        S_OSEND: begin
          if (out_fire) begin
            out_valid_q <= 1'b0;
            oidx_q      <= oidx_q + BINW'(1);
            if (o_last_q) begin
              level_sum_q <= '0;
            end
          end
        end
        default: begin
          out_valid_q <= out_valid_q;
        end
      endcase
    end
  end

  // Datapath; these registers carry payload only and need no reset.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_COLLECT: begin
        smp_q <= sample_i.sample;
        win_q <= asba_pkg::WIN_ROM[cnt_q];
      end
      S_WMUL: p_q <= mul_p;
      S_RDA: begin
        twr_q <= asba_pkg::TW_RE[tw_idx];
        twi_q <= asba_pkg::TW_IM[tw_idx];
      end
      S_RDB: a_q <= work_rdata;
      S_LB:  b_q <= work_rdata;
      S_M0:  p_q <= mul_p;
      S_M1: begin
        acc_q <= p_q;
        p_q   <= mul_p;
      end
      S_M2: begin
        tr_q <= bf_rnd[WW-1:0];
        p_q  <= mul_p;
      end
      S_M3: begin
        acc_q <= p_q;
        p_q   <= mul_p;
      end
      S_M4: ti_q <= bf_rnd[WW-1:0];
      S_WRA: band_acc_q <= '0;
      S_SQ0: p_q <= mul_p;
      S_SQ1: begin
        acc_q <= p_q;
        p_q   <= mul_p;
      end
      S_SQ2: begin
        v_q   <= {sq_sum[SQW-5:0], 4'b0000};
        r_q   <= '0;
        bit_q <= SQW'(1) << (SQW - 2);
      end
      S_ROOT: begin
        // One bit of the root per cycle, restoring form.
        if (take) begin
          v_q <= v_q - trial[SQW-1:0];
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      S_MACC: begin
        if (&k_q[asba_pkg::BAND_SHIFT-1:0]) begin
          band_sum_q[k_q[LOGN-2 -: BANDW]] <= band_next;
          band_acc_q <= '0;
        end else begin
          band_acc_q <= band_next;
        end
      end
      S_FIN: begin
        level_q  <= level_avg[MW-1:0];
        bass_q   <= bass_avg[MW-1:0];
        mid_q    <= mid_avg[MW-1:0];
        treble_q <= treble_avg[MW-1:0];
        beat_q   <= (bass_avg[MW-1:0] > thr_q);
      end
      S_OLD: begin
        o_idx_q  <= asba_pkg::IDX_W'(oidx_q);
        o_mag_q  <= low_rdata;
        o_band_q <= ((BINW+1)'(oidx_q) < (BINW+1)'(asba_pkg::BAND_COUNT)) ? band_avg[MW-1:0]
                                                                        : '0;
        o_last_q <= (oidx_q == BINW'(asba_pkg::SPECTRUM_BINS - 1));
      end
      default: begin
        p_q <= p_q;
      end
    endcase
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.bin_index      = o_idx_q;
  assign result_o.bin_magnitude  = o_mag_q;
  assign result_o.band_average   = o_band_q;
  assign result_o.level          = level_q;
  assign result_o.bass_average   = bass_q;
  assign result_o.mid_average    = mid_q;
  assign result_o.treble_average = treble_q;
  assign result_o.beat           = beat_q;
  assign result_o.last           = o_last_q;

`ifndef SYNTHESIS
  // The block never takes a sample word while a result word is on offer.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sample_i.ready && result_o.valid))
    else $error("sample accepted while a result is pending");

  // The closing word of a frame carries the highest bin number.
  a_last_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.last) |->
      (result_o.bin_index == asba_pkg::IDX_W'(asba_pkg::SPECTRUM_BINS - 1)))
    else $error("last flag on a wrong bin");

  // Band averages appear only on the first band-count words.
  a_band_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && (result_o.bin_index >= asba_pkg::IDX_W'(asba_pkg::BAND_COUNT))) |->
      (result_o.band_average == '0))
    else $error("band average outside the band words");

  // After a word other than the last is taken, the block stays out of capture for the next word.
  a_next_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.ready && !result_o.last) |=> !sample_i.ready)
    else $error("frame output cut short");
`endif

endmodule
